// ----- sv/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and constants for the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int SLOT_W      = 5;
    localparam int TIME_W      = 16;
    localparam int SLICE_W     = 8;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd2;

    localparam logic KIND_ADMIT = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [1:0] ST_ADMITTED = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_DISPATCH = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic [1:0] PRIOR_NONE     = 2'd0;
    localparam logic [1:0] PRIOR_FINISHED = 2'd1;
    localparam logic [1:0] PRIOR_PREEMPT  = 2'd2;

    // lower half / upper half of the shared queue memory
    localparam logic RING_READY = 1'b0;
    localparam logic RING_FREE  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0] burst_time;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] task_slot;
        logic [1:0]        prior_outcome;
        logic [SLOT_W-1:0] prior_slot;
        logic [TIME_W-1:0] time_left;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADMIT,
        S_TICK,
        S_DISP
    } t_state;

endpackage

// ----- sv/round_robin_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Round-robin scheduler: free-slot ring and ready ring share one queue RAM,
// remaining run time per slot lives in a time RAM.
// ----------------------------------------------------------------------------
// Admit: S_IDLE accepts and reads the free-ring head, S_ADMIT registers the output.
// Tick: S_IDLE reads time and ready head, S_TICK writes back, reads dispatched time,
// S_DISP registers the output; S_ADMIT and S_DISP wait for a free output register.
// Words enter only in S_IDLE, also while a result still waits at the output register.
// Reset is synchronous and takes effect at once: no clearing pass; a fill count
// makes unwritten free-ring entries read as their own position.
module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int SLOTS     = 32,
    parameter int TIME_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_word           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_word          o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [SLICE_W-1:0] i_cfg_data
);

    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW     = $clog2(SLOTS + 1);
    localparam int QAW    = SW + 1;
    localparam int QDEPTH = 2 ** QAW;
    localparam int XW     = TIME_BITS + SLICE_W;
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    function automatic logic [SW-1:0] ring_pos(logic [SW-1:0] head, logic [CW-1:0] cnt);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(cnt);
        if (sum >= (CW+1)'(SLOTS)) begin
            sum = sum - (CW+1)'(SLOTS);
        end
        return sum[SW-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_out(logic [SW-1:0] s);
        logic [SW+SLOT_W-1:0] w;
        w = {{SLOT_W{1'b0}}, s};
        return w[SLOT_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] time_out(logic [TIME_BITS-1:0] t);
        logic [TIME_BITS+TIME_W-1:0] w;
        w = {{TIME_W{1'b0}}, t};
        return w[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] time_in(logic [TIME_W-1:0] t);
        logic [TIME_BITS+TIME_W-1:0] w;
        w = {{TIME_BITS{1'b0}}, t};
        return w[TIME_BITS-1:0];
    endfunction

    // memories
    logic [SW-1:0]        queue_mem [QDEPTH];
    logic [TIME_BITS-1:0] time_mem  [SLOTS];
    logic [SW-1:0]        r_q_rd;
    logic [TIME_BITS-1:0] r_t_rd;

    logic                 q_we, q_re, t_we, t_re;
    logic [QAW-1:0]       q_waddr, q_raddr;
    logic [SW-1:0]        q_wdata;
    logic [SW-1:0]        t_waddr, t_raddr;
    logic [TIME_BITS-1:0] t_wdata;

    // control state
    t_state               r_state, n_state;
    logic [SW-1:0]        r_ready_head, n_ready_head;
    logic [CW-1:0]        r_ready_count, n_ready_count;
    logic [SW-1:0]        r_free_head, n_free_head;
    logic [CW-1:0]        r_free_count, n_free_count;
    logic [CW-1:0]        r_fill, n_fill;
    logic                 r_run_valid, n_run_valid;
    logic [SW-1:0]        r_run_slot, n_run_slot;
    logic [SLICE_W-1:0]   r_slice, n_slice;
    logic                 r_out_valid, n_out_valid;

    // payload
    t_out_word            r_out, n_out;
    logic [TIME_BITS-1:0] r_burst, n_burst;
    logic                 r_reject, n_reject;
    logic                 r_fwd, n_fwd;
    logic [TIME_BITS-1:0] r_fwd_time, n_fwd_time;
    logic [1:0]           r_outcome, n_outcome;
    logic [SW-1:0]        r_prior_slot, n_prior_slot;

    logic                 proceed;
    logic [SW-1:0]        w_admit_slot;
    logic                 w_fin, w_pre, w_disp;
    logic [XW-1:0]        w_diff;
    logic [CW-1:0]        w_rc_mid;
    logic [SW-1:0]        w_disp_slot;

    assign proceed     = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);

    // free-ring positions at or past the fill count are unwritten and read as their own position
    assign w_admit_slot = (CW'(r_free_head) < r_fill) ? r_q_rd : r_free_head;

    assign w_diff  = XW'(r_t_rd) - XW'(r_slice);
    assign w_fin   = (XW'(r_t_rd) <= XW'(r_slice)) || (r_ready_count >= SLOTS_C);
    assign w_pre   = r_run_valid && !w_fin;
    assign w_rc_mid    = w_pre ? (r_ready_count + CW'(1)) : r_ready_count;
    assign w_disp      = (w_rc_mid != '0);
    // empty ready ring: the head is the task just requeued
    assign w_disp_slot = (r_ready_count == '0) ? r_run_slot : r_q_rd;

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            queue_mem[q_waddr] <= q_wdata;
        end
        if (q_re) begin
            r_q_rd <= queue_mem[q_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            time_mem[t_waddr] <= t_wdata;
        end
        if (t_re) begin
            r_t_rd <= time_mem[t_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ready_head  <= '0;
            r_ready_count <= '0;
            r_free_head   <= '0;
            r_free_count  <= SLOTS_C;
            r_fill        <= '0;
            r_run_valid   <= 1'b0;
            r_run_slot    <= '0;
            r_slice       <= SLICE_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_ready_head  <= n_ready_head;
            r_ready_count <= n_ready_count;
            r_free_head   <= n_free_head;
            r_free_count  <= n_free_count;
            r_fill        <= n_fill;
            r_run_valid   <= n_run_valid;
            r_run_slot    <= n_run_slot;
            r_slice       <= n_slice;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out        <= n_out;
        r_burst      <= n_burst;
        r_reject     <= n_reject;
        r_fwd        <= n_fwd;
        r_fwd_time   <= n_fwd_time;
        r_outcome    <= n_outcome;
        r_prior_slot <= n_prior_slot;
    end

    always_comb begin
        n_state       = r_state;
        n_ready_head  = r_ready_head;
        n_ready_count = r_ready_count;
        n_free_head   = r_free_head;
        n_free_count  = r_free_count;
        n_fill        = r_fill;
        n_run_valid   = r_run_valid;
        n_run_slot    = r_run_slot;
        n_slice       = (i_cfg_valid) ? i_cfg_data : r_slice;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out         = r_out;
        n_burst       = r_burst;
        n_reject      = r_reject;
        n_fwd         = r_fwd;
        n_fwd_time    = r_fwd_time;
        n_outcome     = r_outcome;
        n_prior_slot  = r_prior_slot;

        q_we    = 1'b0;
        q_waddr = '0;
        q_wdata = '0;
        q_re    = 1'b0;
        q_raddr = '0;
        t_we    = 1'b0;
        t_waddr = '0;
        t_wdata = '0;
        t_re    = 1'b0;
        t_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.kind == KIND_ADMIT) begin
                        n_reject = (r_free_count == '0) || (r_ready_count >= SLOTS_C);
                        n_burst  = time_in(i_in_data.burst_time);
                        q_re     = 1'b1;
                        q_raddr  = {RING_FREE, r_free_head};
                        n_state  = S_ADMIT;
                    end else begin
                        t_re    = 1'b1;
                        t_raddr = r_run_slot;
                        q_re    = 1'b1;
                        q_raddr = {RING_READY, r_ready_head};
                        n_state = S_TICK;
                    end
                end
            end
            S_ADMIT: begin
                if (proceed) begin
                    n_out_valid         = 1'b1;
                    n_out.prior_outcome = PRIOR_NONE;
                    n_out.prior_slot    = '0;
                    if (r_reject) begin
                        n_out.status    = ST_REJECTED;
                        n_out.task_slot = '0;
                        n_out.time_left = '0;
                    end else begin
                        t_we          = 1'b1;
                        t_waddr       = w_admit_slot;
                        t_wdata       = r_burst;
                        q_we          = 1'b1;
                        q_waddr       = {RING_READY, ring_pos(r_ready_head, r_ready_count)};
                        q_wdata       = w_admit_slot;
                        n_ready_count = r_ready_count + CW'(1);
                        n_free_head   = ring_pos(r_free_head, CW'(1));
                        n_free_count  = r_free_count - CW'(1);
                        n_out.status    = ST_ADMITTED;
                        n_out.task_slot = slot_out(w_admit_slot);
                        n_out.time_left = time_out(r_burst);
                    end
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                if (r_run_valid) begin
                    t_we    = 1'b1;
                    t_waddr = r_run_slot;
                    t_wdata = w_fin ? '0 : w_diff[TIME_BITS-1:0];
                    if (w_pre) begin
                        q_we    = 1'b1;
                        q_waddr = {RING_READY, ring_pos(r_ready_head, r_ready_count)};
                        q_wdata = r_run_slot;
                    end else if (r_free_count < SLOTS_C) begin
                        q_we         = 1'b1;
                        q_waddr      = {RING_FREE, ring_pos(r_free_head, r_free_count)};
                        q_wdata      = r_run_slot;
                        n_free_count = r_free_count + CW'(1);
                        if (r_fill < SLOTS_C) begin
                            n_fill = r_fill + CW'(1);
                        end
                    end
                end
                n_outcome    = !r_run_valid ? PRIOR_NONE :
                               (w_fin ? PRIOR_FINISHED : PRIOR_PREEMPT);
                n_prior_slot = r_run_valid ? r_run_slot : '0;
                n_run_valid  = w_disp;
                n_ready_count = w_rc_mid;
                n_fwd        = 1'b0;
                n_fwd_time   = t_wdata;
                if (w_disp) begin
                    n_ready_head  = ring_pos(r_ready_head, CW'(1));
                    n_ready_count = w_rc_mid - CW'(1);
                    n_run_slot    = w_disp_slot;
                    t_re          = 1'b1;
                    t_raddr       = w_disp_slot;
                    // time RAM reads old data on a same-address write
                    n_fwd         = r_run_valid && (w_disp_slot == r_run_slot);
                end
                n_state = S_DISP;
            end
            S_DISP: begin
                if (proceed) begin
                    n_out_valid         = 1'b1;
                    n_out.prior_outcome = r_outcome;
                    n_out.prior_slot    = slot_out(r_prior_slot);
                    if (r_run_valid) begin
                        n_out.status    = ST_DISPATCH;
                        n_out.task_slot = slot_out(r_run_slot);
                        n_out.time_left = time_out(r_fwd ? r_fwd_time : r_t_rd);
                    end else begin
                        n_out.status    = ST_EMPTY;
                        n_out.task_slot = '0;
                        n_out.time_left = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // slots are conserved across free ring, ready ring and the running slot
    a_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_free_count) + int'(r_ready_count) + int'(r_run_valid)) == SLOTS)
        else $error("slot count not conserved");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= SLOTS_C)
        else $error("fill count out of range");

    a_admit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADMIT && proceed && !r_reject && r_run_valid)
            |-> (w_admit_slot != r_run_slot))
        else $error("admit handed out the running slot");

    a_fwd_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP && r_fwd) |-> r_run_valid)
        else $error("forwarded time without a dispatched task");

endmodule

// ----- tb/round_robin_task_scheduler_tb.sv -----
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_tb
// Self-checking bench for the round-robin task scheduler. A scripted opening
// covers reset state, zero and full-scale bursts, finish, preempt and the lone
// task case. Random phases follow, each run at its own time slice, with admit
// heavy, tick heavy and mixed traffic. A shadow scheduler predicts each reply
// word but the fixed script rows; random stalls exercise both handshakes.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_tb;
    import rrts_pkg::*;

    localparam int NUM_SLOTS   = 1 << SLOT_W;
    localparam int STALL_LIMIT = 400;
    localparam int PHASES      = 14;
    localparam int PHASE_WORDS = 100;

    typedef struct packed {
        t_in_word  word;
        logic      fixed;
        t_out_word reply;
    } t_row;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    t_in_word           in_data   = '0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [SLICE_W-1:0] cfg_data  = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    t_out_word          o_out_data;
    logic               o_cfg_ready;

    // shadow scheduler state
    logic [TIME_W-1:0]  slot_time  [NUM_SLOTS];
    logic [SLOT_W-1:0]  ready_ring [NUM_SLOTS];
    logic [SLOT_W-1:0]  free_ring  [NUM_SLOTS];
    int                 ready_head;
    int                 ready_fill;
    int                 free_head;
    int                 free_fill;
    logic               run_valid;
    logic [SLOT_W-1:0]  run_slot;
    logic [SLICE_W-1:0] slice_now;

    t_out_word due_replies[$];
    int        err_count   = 0;
    int        idle_cycles = 0;
    int        sink_hold   = 0;
    bit        idle_on     = 1'b1;

    t_row script [22] = '{
        '{'{KIND_TICK,  16'hFFFF}, 1'b1, '{ST_EMPTY,    5'd0, PRIOR_NONE,     5'd0, 16'h0000}},
        '{'{KIND_ADMIT, 16'h0000}, 1'b1, '{ST_ADMITTED, 5'd0, PRIOR_NONE,     5'd0, 16'h0000}},
        '{'{KIND_ADMIT, 16'hFFFF}, 1'b1, '{ST_ADMITTED, 5'd1, PRIOR_NONE,     5'd0, 16'hFFFF}},
        '{'{KIND_ADMIT, 16'h0003}, 1'b1, '{ST_ADMITTED, 5'd2, PRIOR_NONE,     5'd0, 16'h0003}},
        '{'{KIND_TICK,  16'h0000}, 1'b1, '{ST_DISPATCH, 5'd0, PRIOR_NONE,     5'd0, 16'h0000}},
        '{'{KIND_TICK,  16'h0000}, 1'b1, '{ST_DISPATCH, 5'd1, PRIOR_FINISHED, 5'd0, 16'hFFFF}},
        '{'{KIND_TICK,  16'h0000}, 1'b1, '{ST_DISPATCH, 5'd2, PRIOR_PREEMPT,  5'd1, 16'h0003}},
        '{'{KIND_TICK,  16'h0000}, 1'b1, '{ST_DISPATCH, 5'd1, PRIOR_PREEMPT,  5'd2, 16'hFFFD}},
        '{'{KIND_TICK,  16'h0000}, 1'b1, '{ST_DISPATCH, 5'd2, PRIOR_PREEMPT,  5'd1, 16'h0001}},
        '{'{KIND_TICK,  16'h0000}, 1'b1, '{ST_DISPATCH, 5'd1, PRIOR_FINISHED, 5'd2, 16'hFFFB}},
        '{'{KIND_TICK,  16'h0000}, 1'b1, '{ST_DISPATCH, 5'd1, PRIOR_PREEMPT,  5'd1, 16'hFFF9}},
        '{'{KIND_ADMIT, 16'h0002}, 1'b1, '{ST_ADMITTED, 5'd3, PRIOR_NONE,     5'd0, 16'h0002}},
        '{'{KIND_ADMIT, 16'h8000}, 1'b0, '0},
        '{'{KIND_ADMIT, 16'h5555}, 1'b0, '0},
        '{'{KIND_ADMIT, 16'hAAAA}, 1'b0, '0},
        '{'{KIND_TICK,  16'h1234}, 1'b0, '0},
        '{'{KIND_TICK,  16'h0000}, 1'b0, '0},
        '{'{KIND_TICK,  16'hFFFF}, 1'b0, '0},
        '{'{KIND_TICK,  16'h0000}, 1'b0, '0},
        '{'{KIND_TICK,  16'h0001}, 1'b0, '0},
        '{'{KIND_TICK,  16'h0000}, 1'b0, '0},
        '{'{KIND_TICK,  16'h0000}, 1'b0, '0}
    };

    round_robin_task_scheduler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic t_out_word schedule_step(t_in_word w);
        t_out_word         r;
        logic [SLOT_W-1:0] s;
        logic [TIME_W-1:0] t;
        r = '0;
        if (w.kind == KIND_ADMIT) begin
            if (free_fill == 0 || ready_fill >= NUM_SLOTS) begin
                r.status = ST_REJECTED;
            end else begin
                s = free_ring[free_head];
                free_head = (free_head + 1) % NUM_SLOTS;
                free_fill--;
                slot_time[s] = w.burst_time;
                ready_ring[(ready_head + ready_fill) % NUM_SLOTS] = s;
                ready_fill++;
                r.status    = ST_ADMITTED;
                r.task_slot = s;
                r.time_left = w.burst_time;
            end
        end else begin
            r.prior_outcome = PRIOR_NONE;
            if (run_valid) begin
                s = run_slot;
                t = slot_time[s];
                r.prior_slot = s;
                if (t <= slice_now || ready_fill >= NUM_SLOTS) begin
                    slot_time[s] = '0;
                    if (free_fill < NUM_SLOTS) begin
                        free_ring[(free_head + free_fill) % NUM_SLOTS] = s;
                        free_fill++;
                    end
                    r.prior_outcome = PRIOR_FINISHED;
                end else begin
                    slot_time[s] = t - slice_now;
                    ready_ring[(ready_head + ready_fill) % NUM_SLOTS] = s;
                    ready_fill++;
                    r.prior_outcome = PRIOR_PREEMPT;
                end
                run_valid = 1'b0;
            end
            if (ready_fill > 0) begin
                s = ready_ring[ready_head];
                ready_head = (ready_head + 1) % NUM_SLOTS;
                ready_fill--;
                run_slot    = s;
                run_valid   = 1'b1;
                r.status    = ST_DISPATCH;
                r.task_slot = s;
                r.time_left = slot_time[s];
            end else begin
                r.status = ST_EMPTY;
            end
        end
        return r;
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            err_count++;
        end
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic push_word(t_in_word w, logic fixed, t_out_word reply);
        t_out_word r;
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!o_in_ready);
        r = schedule_step(w);
        due_replies.push_back(fixed ? reply : r);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
    endtask

    task automatic write_slice(logic [SLICE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!o_cfg_ready);
        slice_now = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk) begin
        if (idle_on && sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_hold <= $urandom_range(0, 13);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : reply_check
        t_out_word want;
        if (rst_n && o_out_valid && out_ready) begin
            if (due_replies.size() == 0) begin
                $display("%0t: reply expected none actual %h", $time, o_out_data);
                err_count++;
            end else begin
                want = due_replies.pop_front();
                check_field("status", 32'(want.status), 32'(o_out_data.status));
                check_field("task_slot", 32'(want.task_slot), 32'(o_out_data.task_slot));
                check_field("prior_outcome", 32'(want.prior_outcome),
                            32'(o_out_data.prior_outcome));
                check_field("prior_slot", 32'(want.prior_slot), 32'(o_out_data.prior_slot));
                check_field("time_left", 32'(want.time_left), 32'(o_out_data.time_left));
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
                || (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_in_word           w;
        logic [SLICE_W-1:0] pick;
        int                 mode;
        int                 admit_pct;
        int                 roll;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_time[i]  = '0;
            ready_ring[i] = '0;
            free_ring[i]  = SLOT_W'(i);
        end
        ready_head = 0;
        ready_fill = 0;
        free_head  = 0;
        free_fill  = NUM_SLOTS;
        run_valid  = 1'b0;
        run_slot   = '0;
        slice_now  = SLICE_RESET;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < $size(script); i++)
            push_word(script[i].word, script[i].fixed, script[i].reply);

        for (int p = 0; p < PHASES; p++) begin
            // drain fully before touching the slice
            in_valid <= 1'b0;
            while (due_replies.size() != 0) @(negedge clk);
            repeat (4) @(negedge clk);
            case (p)
                0:       pick = 8'd1;
                1:       pick = 8'd255;
                2:       pick = 8'd2;
                default: pick = ($urandom_range(0, 3) == 0)
                                ? ($urandom_range(0, 1) ? 8'd255 : 8'd1)
                                : SLICE_W'($urandom_range(1, 255));
            endcase
            write_slice(pick);
            idle_on = (p >= PHASES - 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            mode = p % 3;
            // mixed, admit heavy (pool fills, rejects), tick heavy (pool drains)
            admit_pct = (mode == 0) ? 45 : (mode == 1) ? 85 : 15;
            for (int k = 0; k < PHASE_WORDS; k++) begin
                roll = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < admit_pct) begin
                    w.kind = KIND_ADMIT;
                    if (roll < 10)
                        w.burst_time = '0;
                    else if (roll < 60)
                        w.burst_time = TIME_W'($urandom_range(0, 3 * slice_now + 2));
                    else
                        w.burst_time = TIME_W'($urandom_range(0, 65535));
                end else begin
                    w.kind       = KIND_TICK;
                    w.burst_time = TIME_W'($urandom_range(0, 65535));
                end
                push_word(w, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (due_replies.size() != 0) @(negedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
